// ===== rtl/core/dst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants of the source tokenizer
// Token kinds, the token record and the queue sizing.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned KIND_W      = 5;
    localparam int unsigned LINE_W      = 32;
    localparam int unsigned OFFS_W      = 32;
    localparam int unsigned LEN_W       = 8;
    localparam int unsigned VAL_W       = 31;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [LEN_W-1:0] MAX_IDENT_RESET = LEN_W'(20);

    typedef enum logic [KIND_W-1:0] {
        K_ID       = 5'd0,
        K_NUM      = 5'd1,
        K_RNUM     = 5'd2,
        K_PLUS     = 5'd3,
        K_MINUS    = 5'd4,
        K_MUL      = 5'd5,
        K_DIV      = 5'd6,
        K_LT       = 5'd7,
        K_LE       = 5'd8,
        K_GE       = 5'd9,
        K_GT       = 5'd10,
        K_EQ       = 5'd11,
        K_NE       = 5'd12,
        K_DEF      = 5'd13,
        K_ENDDEF   = 5'd14,
        K_DRDEF    = 5'd15,
        K_DRENDDEF = 5'd16,
        K_COLON    = 5'd17,
        K_RANGE    = 5'd18,
        K_SEMI     = 5'd19,
        K_COMMA    = 5'd20,
        K_ASSIGN   = 5'd21,
        K_SQBO     = 5'd22,
        K_SQBC     = 5'd23,
        K_BO       = 5'd24,
        K_BC       = 5'd25,
        K_END      = 5'd26,
        K_ERR      = 5'd27
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [LINE_W-1:0] line;
        logic [OFFS_W-1:0] start;
        logic [LEN_W-1:0]  length;
        logic [VAL_W-1:0]  token_value;
        logic              last;
    } t_token;

    // Tokens produced by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_emit;

endpackage
`default_nettype wire

// ===== rtl/core/dst_channels.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst channels: valid/ready stream interfaces of the source tokenizer
// Byte channel into the block and token channel out of it.
// ----------------------------------------------------------------------------
interface dst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface dst_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [31:0] line_number;
    logic [31:0] token_start;
    logic [7:0]  token_length;
    logic [30:0] token_value;
    logic        last;

    modport source (output valid, output token_kind, output line_number, output token_start,
                    output token_length, output token_value, output last, input ready);
    modport sink   (input valid, input token_kind, input line_number, input token_start,
                    input token_length, input token_value, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dst_lexer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst_lexer_core: lexer DFA with one byte of lookahead
// Holds the scan state and counters, and computes the up to two tokens that
// one byte produces.
// ----------------------------------------------------------------------------
module dst_lexer_core import dst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [LEN_W-1:0]  i_cfg_wr_data,
    input  logic              i_step,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_end_of_input,
    output t_emit             o_emit
);

    typedef enum logic [5:0] {
        S_START   = 6'd0,
        S_ID      = 6'd1,
        S_NUM     = 6'd2,
        S_NUMDOT  = 6'd3,
        S_FRAC    = 6'd4,
        S_EXP     = 6'd5,
        S_EXPSIGN = 6'd6,
        S_EXPDIG  = 6'd7,
        S_DOT     = 6'd8,
        S_STAR    = 6'd9,
        S_CMT     = 6'd10,
        S_CMTSTAR = 6'd11,
        S_EQ      = 6'd12,
        S_BANG    = 6'd13,
        S_LT      = 6'd14,
        S_LTLT    = 6'd15,
        S_GT      = 6'd16,
        S_GTGT    = 6'd17,
        S_COLON   = 6'd18
    } t_state;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_UE    = 8'h45;
    localparam logic [CHAR_W-1:0] CH_LSQ   = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RSQ   = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LE    = 8'h65;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    t_state             r_state, n_state;
    logic [LINE_W-1:0]  r_line, n_line;
    logic [OFFS_W-1:0]  r_offset, n_offset;
    logic [OFFS_W-1:0]  r_lex_start, n_lex_start;
    logic [LEN_W-1:0]   r_lex_len, n_lex_len;
    logic               r_over, n_over;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic [LEN_W-1:0]   r_max_len;

    logic [CHAR_W-1:0]  c;
    logic               is_alpha, is_digit;
    logic [3:0]         digit;
    logic [VAL_W+3:0]   acc_x10;
    logic [VAL_W-1:0]   acc_sat;
    logic [LEN_W-1:0]   grown_len;
    logic               grown_over;
    logic               id_err;
    logic [LINE_W-1:0]  line_inc;

    // start-state decode of the current byte
    logic               ss_begin, ss_single, ss_nl;
    t_state             ss_state;
    t_kind              ss_kind;

    logic               do_grow, do_scan, retract;
    t_kind              ret_kind;
    logic               a_valid, b_valid;
    t_kind              a_kind, b_kind;
    logic [LEN_W-1:0]   a_len, b_len;
    logic [OFFS_W-1:0]  b_start;
    t_token             tok_a, tok_b;

    assign c          = i_char_code;
    assign is_digit   = (c >= 8'h30) && (c <= 8'h39);
    assign is_alpha   = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign digit      = c[3:0];
    assign acc_x10    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {{VAL_W{1'b0}}, digit};
    assign acc_sat    = (acc_x10[VAL_W+3:VAL_W] != 4'b0) ? VAL_MAX : acc_x10[VAL_W-1:0];
    assign grown_len  = (r_lex_len == LEN_MAX) ? LEN_MAX : r_lex_len + 1'b1;
    assign grown_over = r_over || (r_lex_len == LEN_MAX);
    assign id_err     = r_over || (r_lex_len > r_max_len);
    assign line_inc   = (r_line == '1) ? r_line : r_line + 1'b1;

    always_comb begin
        ss_begin  = 1'b0;
        ss_single = 1'b0;
        ss_nl     = 1'b0;
        ss_state  = S_START;
        ss_kind   = K_ERR;
        if (is_alpha) begin
            ss_begin = 1'b1;
            ss_state = S_ID;
        end else if (is_digit) begin
            ss_begin = 1'b1;
            ss_state = S_NUM;
        end else begin
            case (c)
                CH_DOT:   begin ss_begin = 1'b1; ss_state = S_DOT;   end
                CH_STAR:  begin ss_begin = 1'b1; ss_state = S_STAR;  end
                CH_EQ:    begin ss_begin = 1'b1; ss_state = S_EQ;    end
                CH_BANG:  begin ss_begin = 1'b1; ss_state = S_BANG;  end
                CH_LT:    begin ss_begin = 1'b1; ss_state = S_LT;    end
                CH_GT:    begin ss_begin = 1'b1; ss_state = S_GT;    end
                CH_COLON: begin ss_begin = 1'b1; ss_state = S_COLON; end
                CH_SEMI:  begin ss_single = 1'b1; ss_kind = K_SEMI;  end
                CH_COMMA: begin ss_single = 1'b1; ss_kind = K_COMMA; end
                CH_LSQ:   begin ss_single = 1'b1; ss_kind = K_SQBO;  end
                CH_RSQ:   begin ss_single = 1'b1; ss_kind = K_SQBC;  end
                CH_LPAR:  begin ss_single = 1'b1; ss_kind = K_BO;    end
                CH_RPAR:  begin ss_single = 1'b1; ss_kind = K_BC;    end
                CH_PLUS:  begin ss_single = 1'b1; ss_kind = K_PLUS;  end
                CH_MINUS: begin ss_single = 1'b1; ss_kind = K_MINUS; end
                CH_SLASH: begin ss_single = 1'b1; ss_kind = K_DIV;   end
                CH_SPACE, CH_CR, CH_TAB: begin
                end
                CH_LF:    ss_nl = 1'b1;
                default:  begin ss_single = 1'b1; ss_kind = K_ERR;   end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_line      = r_line;
        n_offset    = r_offset;
        n_lex_start = r_lex_start;
        n_lex_len   = r_lex_len;
        n_over      = r_over;
        n_acc       = r_acc;
        do_grow     = 1'b0;
        do_scan     = 1'b0;
        retract     = 1'b0;
        ret_kind    = K_ERR;
        a_valid     = 1'b0;
        a_kind      = K_ERR;
        a_len       = r_lex_len;
        b_valid     = 1'b0;
        b_kind      = K_ERR;
        b_len       = '0;
        b_start     = r_offset;

        if (i_end_of_input) begin
            // flush the pending lexeme, then END; the offset holds
            a_valid = 1'b1;
            case (r_state)
                S_ID:                      a_kind = id_err ? K_ERR : K_ID;
                S_NUM:                     a_kind = K_NUM;
                S_FRAC, S_EXPDIG:          a_kind = K_RNUM;
                S_NUMDOT, S_EXP, S_EXPSIGN,
                S_DOT, S_EQ, S_BANG:       a_kind = K_ERR;
                S_STAR:                    a_kind = K_MUL;
                S_LT:                      a_kind = K_LT;
                S_LTLT:                    a_kind = K_DEF;
                S_GT:                      a_kind = K_GT;
                S_GTGT:                    a_kind = K_ENDDEF;
                S_COLON:                   a_kind = K_COLON;
                default:                   a_valid = 1'b0;
            endcase
            n_state = S_START;
            b_valid = 1'b1;
            b_kind  = K_END;
        end else begin
            n_offset = r_offset + 1'b1;
            case (r_state)
                S_ID: begin
                    if (is_alpha || is_digit || c == CH_UNDER) begin
                        do_grow = 1'b1;
                    end else begin
                        retract  = 1'b1;
                        ret_kind = id_err ? K_ERR : K_ID;
                    end
                end
                S_NUM: begin
                    if (is_digit) begin
                        do_grow = 1'b1;
                        n_acc   = acc_sat;
                    end else if (c == CH_DOT) begin
                        do_grow = 1'b1;
                        n_state = S_NUMDOT;
                    end else begin
                        retract  = 1'b1;
                        ret_kind = K_NUM;
                    end
                end
                S_NUMDOT: begin
                    if (is_digit) begin
                        do_grow = 1'b1;
                        n_state = S_FRAC;
                    end else if (c == CH_DOT) begin
                        // digits then range operator: split into NUM and RANGE
                        a_valid = 1'b1;
                        a_kind  = K_NUM;
                        a_len   = r_over ? LEN_MAX : r_lex_len - 1'b1;
                        b_valid = 1'b1;
                        b_kind  = K_RANGE;
                        b_start = r_offset - 1'b1;
                        b_len   = LEN_W'(2);
                        n_state = S_START;
                    end else begin
                        retract = 1'b1;
                    end
                end
                S_FRAC: begin
                    if (is_digit) begin
                        do_grow = 1'b1;
                    end else if (c == CH_LE || c == CH_UE) begin
                        do_grow = 1'b1;
                        n_state = S_EXP;
                    end else begin
                        retract  = 1'b1;
                        ret_kind = K_RNUM;
                    end
                end
                S_EXP: begin
                    if (is_digit) begin
                        do_grow = 1'b1;
                        n_state = S_EXPDIG;
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        do_grow = 1'b1;
                        n_state = S_EXPSIGN;
                    end else begin
                        retract = 1'b1;
                    end
                end
                S_EXPSIGN: begin
                    if (is_digit) begin
                        do_grow = 1'b1;
                        n_state = S_EXPDIG;
                    end else begin
                        retract = 1'b1;
                    end
                end
                S_EXPDIG: begin
                    if (is_digit) begin
                        do_grow = 1'b1;
                    end else begin
                        retract  = 1'b1;
                        ret_kind = K_RNUM;
                    end
                end
                S_DOT: begin
                    if (c == CH_DOT) begin
                        do_grow = 1'b1;
                        a_valid = 1'b1;
                        a_kind  = K_RANGE;
                        a_len   = grown_len;
                        n_state = S_START;
                    end else begin
                        retract = 1'b1;
                    end
                end
                S_STAR: begin
                    if (c == CH_STAR) begin
                        n_state = S_CMT;
                    end else begin
                        retract  = 1'b1;
                        ret_kind = K_MUL;
                    end
                end
                S_CMT: begin
                    if (c == CH_STAR) begin
                        n_state = S_CMTSTAR;
                    end else if (c == CH_LF) begin
                        n_line = line_inc;
                    end
                end
                S_CMTSTAR: begin
                    if (c == CH_STAR) begin
                        n_state = S_START;
                    end else begin
                        if (c == CH_LF) begin
                            n_line = line_inc;
                        end
                        n_state = S_CMT;
                    end
                end
                S_EQ, S_BANG: begin
                    if (c == CH_EQ) begin
                        do_grow = 1'b1;
                        a_valid = 1'b1;
                        a_kind  = (r_state == S_EQ) ? K_EQ : K_NE;
                        a_len   = grown_len;
                        n_state = S_START;
                    end else begin
                        retract = 1'b1;
                    end
                end
                S_LT, S_GT: begin
                    if (c == ((r_state == S_LT) ? CH_LT : CH_GT)) begin
                        do_grow = 1'b1;
                        n_state = (r_state == S_LT) ? S_LTLT : S_GTGT;
                    end else if (c == CH_EQ) begin
                        do_grow = 1'b1;
                        a_valid = 1'b1;
                        a_kind  = (r_state == S_LT) ? K_LE : K_GE;
                        a_len   = grown_len;
                        n_state = S_START;
                    end else begin
                        retract  = 1'b1;
                        ret_kind = (r_state == S_LT) ? K_LT : K_GT;
                    end
                end
                S_LTLT, S_GTGT: begin
                    if (c == ((r_state == S_LTLT) ? CH_LT : CH_GT)) begin
                        do_grow = 1'b1;
                        a_valid = 1'b1;
                        a_kind  = (r_state == S_LTLT) ? K_DRDEF : K_DRENDDEF;
                        a_len   = grown_len;
                        n_state = S_START;
                    end else begin
                        retract  = 1'b1;
                        ret_kind = (r_state == S_LTLT) ? K_DEF : K_ENDDEF;
                    end
                end
                S_COLON: begin
                    if (c == CH_EQ) begin
                        do_grow = 1'b1;
                        a_valid = 1'b1;
                        a_kind  = K_ASSIGN;
                        a_len   = grown_len;
                        n_state = S_START;
                    end else begin
                        retract  = 1'b1;
                        ret_kind = K_COLON;
                    end
                end
                default: do_scan = 1'b1;
            endcase

            if (do_grow) begin
                n_lex_len = grown_len;
                n_over    = grown_over;
            end

            // emit the pending lexeme, then rescan the retracted byte
            if (retract) begin
                a_valid = 1'b1;
                a_kind  = ret_kind;
                do_scan = 1'b1;
            end

            if (do_scan) begin
                n_state = ss_state;
                if (ss_begin) begin
                    n_lex_start = r_offset;
                    n_lex_len   = LEN_W'(1);
                    n_over      = 1'b0;
                    n_acc       = is_digit ? VAL_W'(digit) : '0;
                end
                if (ss_single) begin
                    b_valid = 1'b1;
                    b_kind  = ss_kind;
                    b_len   = LEN_W'(1);
                end
                if (ss_nl) begin
                    n_line = line_inc;
                end
            end
        end
    end

    always_comb begin
        tok_a.kind        = a_kind;
        tok_a.line        = r_line;
        tok_a.start       = r_lex_start;
        tok_a.length      = a_len;
        tok_a.token_value = (a_kind == K_NUM) ? r_acc : '0;
        tok_a.last        = !b_valid;
        tok_b.kind        = b_kind;
        tok_b.line        = r_line;
        tok_b.start       = b_start;
        tok_b.length      = b_len;
        tok_b.token_value = '0;
        tok_b.last        = 1'b1;
        o_emit.count      = i_step ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;
        o_emit.tok0       = a_valid ? tok_a : tok_b;
        o_emit.tok1       = tok_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_START;
            r_line      <= LINE_W'(1);
            r_offset    <= '0;
            r_lex_start <= '0;
            r_lex_len   <= '0;
            r_over      <= 1'b0;
            r_acc       <= '0;
            r_max_len   <= MAX_IDENT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_state     <= n_state;
                r_line      <= n_line;
                r_offset    <= n_offset;
                r_lex_start <= n_lex_start;
                r_lex_len   <= n_lex_len;
                r_over      <= n_over;
                r_acc       <= n_acc;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dst_token_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst_token_fifo: token result queue
// Takes up to two tokens a cycle from the lexer and hands out one word a cycle while popped.
// ----------------------------------------------------------------------------
module dst_token_fifo import dst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_emit             i_emit,
    input  logic              i_pop,
    output t_token            o_head,
    output logic              o_valid,
    output logic              o_room,
    output logic [QLVL_W-1:0] o_level
);

    t_token              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QLVL_W-1:0]   r_level;
    logic [QPTR_W-1:0]   wp_next;
    logic                pop;

    assign wp_next = r_wp + 1'b1;
    assign pop     = i_pop && (r_level != '0);
    assign o_head  = r_mem[r_rp];
    assign o_valid = (r_level != '0);
    // room for a full two-token word pair
    assign o_room  = (r_level <= QLVL_W'(QUEUE_DEPTH - 2));
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_wp] <= i_emit.tok0;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[wp_next] <= i_emit.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= r_wp + QPTR_W'(i_emit.count);
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_level <= r_level + QLVL_W'(i_emit.count) - QLVL_W'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dst_source_tokenizer.sv =====
`default_nettype none
// A token is written into the token queue as the byte that ends it is accepted; it is offered from the queue head.
// Throughput: one source byte per cycle while ready is high; a byte that yields two
// tokens is absorbed by the four-word token queue (ready drops below two free).
// Reset: synchronous, active low; DFA at start, line 1, offset 0, queue empty,
// identifier limit 20. No clearing pass.
// ----------------------------------------------------------------------------
// dfa_source_tokenizer: streaming lexical analyzer
// Lexer DFA with one byte of lookahead feeding a small token queue.
// ----------------------------------------------------------------------------
module dfa_source_tokenizer import dst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    dst_in_if.sink           i_in_chan,
    dst_out_if.source        o_tok_chan
);

    t_emit              w_emit;
    t_token             w_head;
    logic               w_step;
    logic               w_room;
    logic               w_valid;
    logic               w_pop;
    logic [QLVL_W-1:0]  w_level;

    assign i_in_chan.ready = w_room;
    assign w_step          = i_in_chan.valid && w_room;
    assign w_pop           = o_tok_chan.ready;

    dst_lexer_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_step         (w_step),
        .i_char_code    (i_in_chan.char_code),
        .i_end_of_input (i_in_chan.end_of_input),
        .o_emit         (w_emit)
    );

    dst_token_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_valid (w_valid),
        .o_room  (w_room),
        .o_level (w_level)
    );

    assign o_tok_chan.valid        = w_valid;
    assign o_tok_chan.token_kind   = w_head.kind;
    assign o_tok_chan.line_number  = w_head.line;
    assign o_tok_chan.token_start  = w_head.start;
    assign o_tok_chan.token_length = w_head.length;
    assign o_tok_chan.token_value  = w_head.token_value;
    assign o_tok_chan.last         = w_head.last;

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= QLVL_W'(QUEUE_DEPTH))
        else $error("token queue overrun");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && i_in_chan.end_of_input) |-> (w_emit.count != 2'd0))
        else $error("end of input gave no token");

    a_last_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit.count == 2'd2) |-> (w_emit.tok1.last && !w_emit.tok0.last))
        else $error("last flag on wrong token of a pair");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid |-> (o_tok_chan.line_number != '0))
        else $error("token with line number zero");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/dst_token_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dst_token_checker: token prediction and comparison for the source tokenizer
// Watches both channels and the limit register write port. Every accepted
// source word runs through a local lexer that produces the tokens the block
// should emit. Every accepted token is compared field by field with the oldest
// one still waiting.
// ----------------------------------------------------------------------------
module dst_token_checker import dst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    dst_in_if                i_in_mon,
    dst_out_if               i_tok_mon,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    localparam logic [VAL_W-1:0] NUM_SAT = {VAL_W{1'b1}};
    localparam int MAX_PRINTED = 40;

    typedef enum logic [4:0] {
        ST_START, ST_ID, ST_NUM, ST_NUMDOT, ST_FRAC, ST_EXP, ST_EXPSIGN, ST_EXPDIG,
        ST_DOT, ST_STAR, ST_CMT, ST_CMTSTAR, ST_EQ, ST_BANG, ST_LT, ST_LTLT,
        ST_GT, ST_GTGT, ST_COLON
    } t_lex_state;

    t_lex_state        lex_state;
    logic [LINE_W-1:0] cur_line;
    logic [OFFS_W-1:0] next_offset;
    logic [OFFS_W-1:0] lex_start;
    logic [LEN_W-1:0]  lex_len;
    logic              len_over;
    logic [VAL_W-1:0]  num_acc;
    logic [LEN_W-1:0]  ident_limit;

    t_token expected_tokens [$];
    int     fail_cnt = 0;
    int     checked_cnt = 0;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void reset_lexer();
        lex_state   = ST_START;
        cur_line    = LINE_W'(1);
        next_offset = '0;
        lex_start   = '0;
        lex_len     = '0;
        len_over    = 1'b0;
        num_acc     = '0;
        ident_limit = MAX_IDENT_RESET;
    endfunction

    function automatic void emit(input t_kind k, input logic [OFFS_W-1:0] st,
                                 input logic [LEN_W-1:0] len, input logic [VAL_W-1:0] val);
        t_token t;
        t.kind        = k;
        t.line        = cur_line;
        t.start       = st;
        t.length      = len;
        t.token_value = val;
        t.last        = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void emit_lexeme(input t_kind k);
        emit(k, lex_start, lex_len, (k == K_NUM) ? num_acc : '0);
    endfunction

    function automatic t_kind ident_kind();
        return (len_over || lex_len > ident_limit) ? K_ERR : K_ID;
    endfunction

    function automatic void grow();
        if (lex_len == {LEN_W{1'b1}}) len_over = 1'b1;
        else lex_len++;
    endfunction

    function automatic void bump_line();
        if (cur_line != {LINE_W{1'b1}}) cur_line++;
    endfunction

    function automatic void open_lexeme(input logic [OFFS_W-1:0] pos, input t_lex_state st);
        lex_start = pos;
        lex_len   = LEN_W'(1);
        len_over  = 1'b0;
        num_acc   = '0;
        lex_state = st;
    endfunction

    function automatic void scan_fresh(input logic [7:0] c, input logic [OFFS_W-1:0] pos);
        lex_state = ST_START;
        if (is_alpha(c)) open_lexeme(pos, ST_ID);
        else if (is_digit(c)) begin
            open_lexeme(pos, ST_NUM);
            num_acc = VAL_W'(c - 8'h30);
        end else begin
            case (c)
                ".":    open_lexeme(pos, ST_DOT);
                "*":    open_lexeme(pos, ST_STAR);
                "=":    open_lexeme(pos, ST_EQ);
                "!":    open_lexeme(pos, ST_BANG);
                "<":    open_lexeme(pos, ST_LT);
                ">":    open_lexeme(pos, ST_GT);
                ":":    open_lexeme(pos, ST_COLON);
                ";":    emit(K_SEMI, pos, 8'd1, '0);
                ",":    emit(K_COMMA, pos, 8'd1, '0);
                "[":    emit(K_SQBO, pos, 8'd1, '0);
                "]":    emit(K_SQBC, pos, 8'd1, '0);
                "(":    emit(K_BO, pos, 8'd1, '0);
                ")":    emit(K_BC, pos, 8'd1, '0);
                "+":    emit(K_PLUS, pos, 8'd1, '0);
                "-":    emit(K_MINUS, pos, 8'd1, '0);
                "/":    emit(K_DIV, pos, 8'd1, '0);
                " ", 8'h0D, 8'h09: ;
                8'h0A:  bump_line();
                default: emit(K_ERR, pos, 8'd1, '0);
            endcase
        end
    endfunction

    function automatic void flush_pending();
        case (lex_state)
            ST_ID:                 emit_lexeme(ident_kind());
            ST_NUM:                emit_lexeme(K_NUM);
            ST_FRAC, ST_EXPDIG:    emit_lexeme(K_RNUM);
            ST_NUMDOT, ST_EXP, ST_EXPSIGN, ST_DOT, ST_EQ, ST_BANG: emit_lexeme(K_ERR);
            ST_STAR:               emit_lexeme(K_MUL);
            ST_LT:                 emit_lexeme(K_LT);
            ST_LTLT:               emit_lexeme(K_DEF);
            ST_GT:                 emit_lexeme(K_GT);
            ST_GTGT:               emit_lexeme(K_ENDDEF);
            ST_COLON:              emit_lexeme(K_COLON);
            default: ;
        endcase
        lex_state = ST_START;
    endfunction

    function automatic void mark_last(input int first_new);
        if (expected_tokens.size() > first_new)
            expected_tokens[expected_tokens.size()-1].last = 1'b1;
    endfunction

    // Advance the lexer by one source word and queue the tokens it yields
    function automatic void tokenize_word(input logic [7:0] c, input logic eoi);
        logic [OFFS_W-1:0] pos;
        logic [34:0]       wide;
        int                first_new;
        logic              rescan;
        t_kind             held;
        pos       = next_offset;
        first_new = expected_tokens.size();
        rescan    = 1'b0;
        held      = K_ERR;
        if (eoi) begin
            flush_pending();
            emit(K_END, next_offset, '0, '0);
            mark_last(first_new);
            return;
        end
        case (lex_state)
            ST_ID: begin
                if (is_alpha(c) || is_digit(c) || c == "_") grow();
                else begin
                    rescan = 1'b1;
                    held   = ident_kind();
                end
            end
            ST_NUM: begin
                if (is_digit(c)) begin
                    grow();
                    wide    = 35'(num_acc) * 35'd10 + 35'(c - 8'h30);
                    num_acc = (wide > 35'(NUM_SAT)) ? NUM_SAT : wide[VAL_W-1:0];
                end else if (c == ".") begin
                    grow();
                    lex_state = ST_NUMDOT;
                end else begin
                    rescan = 1'b1;
                    held   = K_NUM;
                end
            end
            ST_NUMDOT: begin
                if (is_digit(c)) begin
                    grow();
                    lex_state = ST_FRAC;
                end else if (c == ".") begin
                    // split into the number and a range operator
                    emit(K_NUM, lex_start, len_over ? 8'hFF : lex_len - 8'd1, num_acc);
                    emit(K_RANGE, pos - 32'd1, 8'd2, '0);
                    lex_state = ST_START;
                end else rescan = 1'b1;
            end
            ST_FRAC: begin
                if (is_digit(c)) grow();
                else if (c == "e" || c == "E") begin
                    grow();
                    lex_state = ST_EXP;
                end else begin
                    rescan = 1'b1;
                    held   = K_RNUM;
                end
            end
            ST_EXP: begin
                if (is_digit(c)) begin
                    grow();
                    lex_state = ST_EXPDIG;
                end else if (c == "+" || c == "-") begin
                    grow();
                    lex_state = ST_EXPSIGN;
                end else rescan = 1'b1;
            end
            ST_EXPSIGN: begin
                if (is_digit(c)) begin
                    grow();
                    lex_state = ST_EXPDIG;
                end else rescan = 1'b1;
            end
            ST_EXPDIG: begin
                if (is_digit(c)) grow();
                else begin
                    rescan = 1'b1;
                    held   = K_RNUM;
                end
            end
            ST_DOT: begin
                if (c == ".") begin
                    grow();
                    emit_lexeme(K_RANGE);
                    lex_state = ST_START;
                end else rescan = 1'b1;
            end
            ST_STAR: begin
                if (c == "*") lex_state = ST_CMT;
                else begin
                    rescan = 1'b1;
                    held   = K_MUL;
                end
            end
            ST_CMT: begin
                if (c == "*") lex_state = ST_CMTSTAR;
                else if (c == 8'h0A) bump_line();
            end
            ST_CMTSTAR: begin
                if (c == "*") lex_state = ST_START;
                else begin
                    if (c == 8'h0A) bump_line();
                    lex_state = ST_CMT;
                end
            end
            ST_EQ, ST_BANG: begin
                if (c == "=") begin
                    grow();
                    emit_lexeme(lex_state == ST_EQ ? K_EQ : K_NE);
                    lex_state = ST_START;
                end else rescan = 1'b1;
            end
            ST_LT, ST_GT: begin
                if (c == (lex_state == ST_LT ? "<" : ">")) begin
                    grow();
                    lex_state = (lex_state == ST_LT) ? ST_LTLT : ST_GTGT;
                end else if (c == "=") begin
                    grow();
                    emit_lexeme(lex_state == ST_LT ? K_LE : K_GE);
                    lex_state = ST_START;
                end else begin
                    rescan = 1'b1;
                    held   = (lex_state == ST_LT) ? K_LT : K_GT;
                end
            end
            ST_LTLT, ST_GTGT: begin
                if (c == (lex_state == ST_LTLT ? "<" : ">")) begin
                    grow();
                    emit_lexeme(lex_state == ST_LTLT ? K_DRDEF : K_DRENDDEF);
                    lex_state = ST_START;
                end else begin
                    rescan = 1'b1;
                    held   = (lex_state == ST_LTLT) ? K_DEF : K_ENDDEF;
                end
            end
            ST_COLON: begin
                if (c == "=") begin
                    grow();
                    emit_lexeme(K_ASSIGN);
                    lex_state = ST_START;
                end else begin
                    rescan = 1'b1;
                    held   = K_COLON;
                end
            end
            default: scan_fresh(c, pos);
        endcase
        // close the lexeme at the lookahead, then scan that word from the start
        if (rescan) begin
            emit_lexeme(held);
            scan_fresh(c, pos);
        end
        next_offset = pos + 32'd1;
        mark_last(first_new);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_cnt < MAX_PRINTED)
            $display("MISMATCH token %0d: %s is %0d, expected %0d", checked_cnt, field, got,
                     want);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            reset_lexer();
            expected_tokens.delete();
        end else begin
            if (i_cfg_wr_en) ident_limit = i_cfg_wr_data;
            if (i_in_mon.valid && i_in_mon.ready)
                tokenize_word(i_in_mon.char_code, i_in_mon.end_of_input);
            if (i_tok_mon.valid && i_tok_mon.ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected token, kind", 32'(i_tok_mon.token_kind), '0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_tok_mon.token_kind !== want.kind)
                        report_mismatch("kind", 32'(i_tok_mon.token_kind), 32'(want.kind));
                    if (i_tok_mon.line_number !== want.line)
                        report_mismatch("line", i_tok_mon.line_number, want.line);
                    if (i_tok_mon.token_start !== want.start)
                        report_mismatch("start", i_tok_mon.token_start, want.start);
                    if (i_tok_mon.token_length !== want.length)
                        report_mismatch("length", 32'(i_tok_mon.token_length), 32'(want.length));
                    if (i_tok_mon.token_value !== want.token_value)
                        report_mismatch("value", 32'(i_tok_mon.token_value),
                                        32'(want.token_value));
                    if (i_tok_mon.last !== want.last)
                        report_mismatch("last", 32'(i_tok_mon.last), 32'(want.last));
                    checked_cnt++;
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_tokens.size();
        o_checked    <= checked_cnt;
    end

endmodule
`default_nettype wire

// ===== tb/sv/dfa_source_tokenizer_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfa_source_tokenizer_tb: stream test of the source tokenizer
// Feeds short directed byte strings, then random source text built mostly
// from well-formed lexemes with noise and broken lexemes mixed in, under
// several identifier limits. Sender bursts and receiver stalls are random;
// one long receiver hold-off backs the token queue up into the input.
// ----------------------------------------------------------------------------
module dfa_source_tokenizer_tb;
    import dst_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct {
        logic [7:0] code;
        logic       eoi;
    } t_src_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;
    logic             rx_long_hold;

    int fail_count;
    int pending_tokens;
    int checked_tokens;
    int sent_words = 0;
    int idle_cycles = 0;

    logic [7:0] limit_now = MAX_IDENT_RESET;
    logic [7:0] mid_limit;
    t_src_word  src_q [$];

    string op_text [23] = '{"+", "-", "*", "/", "<", "<=", "<<", "<<<", ">", ">=", ">>",
                            ">>>", ":", ":=", "==", "!=", "..", ";", ",", "[", "]", "(", ")"};
    string broken_text [6] = '{"=", "!", ".", "5.", "5.5e", "5.5e+"};
    string blank_text = " \t\r\n";
    string cmt_text   = "ab *\n9+";

    dst_in_if  in_chan ();
    dst_out_if tok_chan ();

    dfa_source_tokenizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_chan     (in_chan),
        .o_tok_chan    (tok_chan)
    );

    dst_token_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_mon      (in_chan),
        .i_tok_mon     (tok_chan),
        .o_fail_count  (fail_count),
        .o_pending     (pending_tokens),
        .o_checked     (checked_tokens)
    );

    always #5 i_clk = ~i_clk;

    // Stop if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_chan.valid && in_chan.ready) || (tok_chan.valid && tok_chan.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("No word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Token receiver: random stall modes, plus one long hold-off on request
    initial begin : token_receiver
        int hold_left;
        int window;
        int mode;
        bit hold_used;
        hold_left = 0;
        window    = 0;
        mode      = 0;
        hold_used = 0;
        tok_chan.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (window == 0) begin
                mode   = $urandom_range(0, 3);
                window = $urandom_range(8, 64);
            end
            window--;
            if (hold_left > 0) begin
                hold_left--;
                tok_chan.ready <= 1'b0;
            end else if (rx_long_hold && !hold_used) begin
                hold_used = 1;
                hold_left = HOLD_CYCLES;
                tok_chan.ready <= 1'b0;
            end else begin
                case (mode)
                    0: tok_chan.ready <= 1'b1;
                    1: tok_chan.ready <= ($urandom_range(0, 3) != 0);
                    2: tok_chan.ready <= ($urandom_range(0, 3) == 0);
                    default: tok_chan.ready <= ~tok_chan.ready;
                endcase
            end
        end
    end

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'h61 + 8'(r) : 8'h41 + 8'(r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic void push_word(input logic [7:0] c, input logic eoi);
        t_src_word w;
        w.code = c;
        w.eoi  = eoi;
        src_q.push_back(w);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
    endfunction

    function automatic void push_digits(input int n);
        for (int i = 0; i < n; i++) push_word(rand_digit(), 1'b0);
    endfunction

    function automatic void push_ident(input int n);
        int r;
        push_word(rand_alpha(), 1'b0);
        for (int i = 1; i < n; i++) begin
            r = $urandom_range(0, 62);
            if (r < 52) push_word(rand_alpha(), 1'b0);
            else if (r < 62) push_word(rand_digit(), 1'b0);
            else push_word("_", 1'b0);
        end
    endfunction

    // One random lexeme, mostly well formed, with an optional blank after it
    function automatic void push_random_lexeme();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            if ($urandom_range(0, 7) == 0) n = int'(limit_now) + $urandom_range(0, 2) - 1;
            else n = $urandom_range(1, 8);
            push_ident(n < 1 ? 1 : n);
        end else if (pick < 34) begin
            push_digits(($urandom_range(0, 5) == 0) ? $urandom_range(10, 12)
                                                      : $urandom_range(1, 4));
        end else if (pick < 42) begin
            push_digits($urandom_range(1, 3));
            push_word(".", 1'b0);
            push_digits($urandom_range(1, 3));
            if ($urandom_range(0, 1)) begin
                push_word($urandom_range(0, 1) ? "e" : "E", 1'b0);
                n = $urandom_range(0, 2);
                if (n == 1) push_word("+", 1'b0);
                else if (n == 2) push_word("-", 1'b0);
                push_digits($urandom_range(1, 2));
            end
        end else if (pick < 62) begin
            push_text(op_text[$urandom_range(0, 22)]);
        end else if (pick < 68) begin
            push_text("**");
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
                push_word(cmt_text[$urandom_range(0, cmt_text.len() - 1)], 1'b0);
            push_text("**");
        end else if (pick < 76) begin
            push_word(blank_text[$urandom_range(0, 3)], 1'b0);
        end else if (pick < 84) begin
            push_text(broken_text[$urandom_range(0, 5)]);
            push_word(rand_alpha(), 1'b0);
        end else if (pick < 92) begin
            push_word(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 94) begin
            push_word(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            push_digits($urandom_range(1, 3));
            push_text("..");
            push_digits($urandom_range(1, 3));
        end
        if ($urandom_range(0, 1)) push_word(" ", 1'b0);
    endfunction

    function automatic void fill_random(input int n);
        while (src_q.size() < n) push_random_lexeme();
    endfunction

    // Drain src_q onto the byte channel; steady drops the gaps between bursts
    task automatic send_words(input bit steady);
        int burst;
        int gap;
        burst = 0;
        while (src_q.size() > 0) begin
            if (burst == 0)
                burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 120)
                                                    : $urandom_range(1, 12);
            in_chan.valid        <= 1'b1;
            in_chan.char_code    <= src_q[0].code;
            in_chan.end_of_input <= src_q[0].eoi;
            @(posedge i_clk);
            while (!in_chan.ready) @(posedge i_clk);
            void'(src_q.pop_front());
            sent_words++;
            burst--;
            if (burst == 0 && !steady) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    in_chan.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        in_chan.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_tokens != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        limit_now = v;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        rx_long_hold         <= 1'b0;
        in_chan.valid        <= 1'b0;
        in_chan.char_code    <= '0;
        in_chan.end_of_input <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // broken lexemes, number before a range, extreme bytes, flush of an
        // incomplete exponent, then end with nothing pending
        push_text("=x!x.x5.x5.5ex5.5e+x7..");
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_text("4.5e");
        push_word(8'($urandom_range(0, 255)), 1'b1);
        push_word(8'($urandom_range(0, 255)), 1'b1);
        send_words(1'b0);

        // widest limit: length saturation on identifiers and numbers
        wait_drained();
        write_limit(8'd255);
        push_ident(260);
        push_word(" ", 1'b0);
        push_digits(300);
        push_text("..");
        push_digits(270);
        push_word(";", 1'b0);
        fill_random(src_q.size() + 100);
        send_words(1'b0);

        wait_drained();
        write_limit(8'd1);
        fill_random(120);
        send_words(1'b0);

        // long receiver hold-off while words keep coming
        wait_drained();
        mid_limit = 8'($urandom_range(2, 254));
        write_limit(mid_limit);
        rx_long_hold <= 1'b1;
        fill_random(160);
        send_words(1'b1);
        fill_random(80);
        send_words(1'b0);

        wait_drained();
        write_limit(MAX_IDENT_RESET);
        fill_random(120);
        push_word(8'h00, 1'b1);
        send_words(1'b0);

        wait_drained();
        $display("Sent %0d source words under identifier limits 20, 255, 1, %0d and 20",
                 sent_words, mid_limit);
        $display("Compared %0d tokens, with one long output hold-off", checked_tokens);
        if (fail_count == 0 && pending_tokens == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/dst_pkg.sv
rtl/core/dst_channels.sv
rtl/core/dst_lexer_core.sv
rtl/core/dst_token_fifo.sv
rtl/core/dst_source_tokenizer.sv
tb/sv/dst_token_checker.sv
tb/sv/dfa_source_tokenizer_tb.sv
